// ===== rtl/core/meti_pkg.sv =====
// ----------------------------------------------------------------------------
// meti_pkg: shared types and constants of the escape-time core
// Field widths, the job word passed from front to engine, queue status
// and the engine state encoding.
// ----------------------------------------------------------------------------
package meti_pkg;

   // fixed field widths
   localparam int C_WIDTH       = 31;   // c_re / c_im, signed
   localparam int Z_WIDTH       = 32;   // z_re / z_im, signed
   localparam int MAG_WIDTH     = 35;   // |z|^2, unsigned
   localparam int CNT_OUT_WIDTH = 16;   // iteration_count
   localparam int CSR_WIDTH     = 16;   // max_iterations register write data
   localparam int PROD_WIDTH    = 2 * Z_WIDTH;

   // queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // largest |z|^2 the result word can show
   localparam logic [PROD_WIDTH-1:0] MAG_MAX = {{(PROD_WIDTH-MAG_WIDTH){1'b0}},
                                                 {MAG_WIDTH{1'b1}}};

   // one point on its way from front to engine
   typedef struct packed {
      logic signed [C_WIDTH-1:0] c_re;
      logic signed [C_WIDTH-1:0] c_im;
      logic                      zero_count;   // no iteration to run
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_ADD,
      ENG_MUL
   } eng_state_type;

endpackage

// ===== rtl/core/meti_req_if.sv =====
// ----------------------------------------------------------------------------
// meti_req_if: request channel of the escape-time core
// Carries one point c per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface meti_req_if;

   logic                                 valid;
   logic                                 ready;
   logic signed [meti_pkg::C_WIDTH-1:0]  c_re;
   logic signed [meti_pkg::C_WIDTH-1:0]  c_im;

   modport source (output valid, output c_re, output c_im, input ready);
   modport sink   (input valid, input c_re, input c_im, output ready);

endinterface

// ===== rtl/core/meti_rsp_if.sv =====
// ----------------------------------------------------------------------------
// meti_rsp_if: response channel of the escape-time core
// Carries one escape-time result per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface meti_rsp_if;

   logic                                      valid;
   logic                                      ready;
   logic [meti_pkg::CNT_OUT_WIDTH-1:0]        iteration_count;
   logic                                      inside_res;
   logic signed [meti_pkg::Z_WIDTH-1:0]       z_re;
   logic signed [meti_pkg::Z_WIDTH-1:0]       z_im;
   logic [meti_pkg::MAG_WIDTH-1:0]            magnitude_sq;

   modport source (output valid, output iteration_count, output inside_res,
                   output z_re, output z_im, output magnitude_sq, input ready);
   modport sink   (input valid, input iteration_count, input inside_res,
                   input z_re, input z_im, input magnitude_sq, output ready);

endinterface

// ===== rtl/core/meti_front.sv =====
// ----------------------------------------------------------------------------
// meti_front: request intake
// Registers each accepted point and tags it when the iteration limit is
// zero, then hands it to the job queue.
// ----------------------------------------------------------------------------
module meti_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   meti_req_if.sink                req,
   input  logic [COUNT_WIDTH-1:0]  max_iter,
   output logic                    push_valid,
   output meti_pkg::job_type       push_job,
   input  logic                    push_ready
);

   logic              slot_valid_ff, slot_valid_in;
   meti_pkg::job_type slot_ff;
   logic              accept;

   // slot frees when the queue takes it
   assign req.ready = !slot_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
      end else if (push_ready) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // classify: a zero limit means the result is known at once
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff.c_re       <= req.c_re;
         slot_ff.c_im       <= req.c_im;
         slot_ff.zero_count <= (max_iter == '0);
      end
   end

   assign push_valid = slot_valid_ff;
   assign push_job   = slot_ff;

endmodule

// ===== rtl/core/meti_queue.sv =====
// ----------------------------------------------------------------------------
// meti_queue: job queue
// Small FIFO of jobs between the front and the iteration engine.
// ----------------------------------------------------------------------------
module meti_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  meti_pkg::job_type          push_job,
   output logic                       push_ready,
   input  logic                       pop,
   output meti_pkg::job_type          pop_job,
   output meti_pkg::queue_status_type status
);

   localparam int Depth = meti_pkg::QUEUE_DEPTH;
   localparam int PtrW  = meti_pkg::QUEUE_PTR_W;

   meti_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PtrW+1)'(Depth));
   assign push_ready   = !status.full;
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/meti_engine.sv =====
// ----------------------------------------------------------------------------
// meti_engine: iteration engine
// Runs z = z*z + c for one job at a time: a multiply state forms re^2,
// im^2 and re*im, an add state tests |z|^2 and builds the next z. The
// finished result lands in the response register.
// ----------------------------------------------------------------------------
module meti_engine #(
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [COUNT_WIDTH-1:0]     max_iter,
   input  meti_pkg::queue_status_type q_status,
   input  meti_pkg::job_type          job,
   output logic                       pop,
   meti_rsp_if.source                 rsp
);

   localparam int ZW   = meti_pkg::Z_WIDTH;
   localparam int PW   = meti_pkg::PROD_WIDTH;
   localparam int CW   = meti_pkg::C_WIDTH;
   localparam int MW   = meti_pkg::MAG_WIDTH;
   localparam int OutW = meti_pkg::CNT_OUT_WIDTH;
   localparam logic [PW-1:0]        MagLimit = PW'(4) << FRAC_BITS;
   localparam logic signed [PW-1:0] SatHi    = PW'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [PW-1:0] SatLo    = PW'(64'shFFFF_FFFF_8000_0000);

   meti_pkg::eng_state_type state_ff, state_in;

   logic signed [CW-1:0]    c_re_ff, c_im_ff;
   logic                    zero_ff;
   logic                    first_ff;
   logic signed [ZW-1:0]    re_ff, im_ff;
   logic signed [PW-1:0]    rr_ff, ii_ff, ri_ff;
   logic [COUNT_WIDTH-1:0]  cnt_ff;

   logic                    out_valid_ff;
   logic [OutW-1:0]         out_count_ff, out_count_in;
   logic                    out_inside_ff, out_inside_in;
   logic signed [ZW-1:0]    out_re_ff, out_im_ff;
   logic [MW-1:0]           out_mag_ff, out_mag_in;

   logic                    out_free;
   logic                    load_job;
   logic                    do_mul;
   logic                    do_step;
   logic                    finish;
   logic [PW-1:0]           mag_sum;
   logic [PW-1:0]           mag_full;
   logic [PW-1:0]           mag_sat;
   logic                    escape;
   logic [COUNT_WIDTH:0]    cnt_inc;
   logic                    at_limit;
   logic signed [PW-1:0]    diff;
   logic signed [PW-1:0]    re_next, im_next;

   function automatic logic signed [ZW-1:0] sat_z(input logic signed [PW-1:0] v);
      logic signed [ZW-1:0] r;
      if (v > SatHi) begin
         r = SatHi[ZW-1:0];
      end else if (v < SatLo) begin
         r = SatLo[ZW-1:0];
      end else begin
         r = v[ZW-1:0];
      end
      return r;
   endfunction

   assign out_free = !out_valid_ff || rsp.ready;

   // magnitude of current z from its squared parts
   assign mag_sum  = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign mag_full = mag_sum >> FRAC_BITS;
   assign mag_sat  = (mag_full > meti_pkg::MAG_MAX) ? meti_pkg::MAG_MAX : mag_full;
   assign escape   = !first_ff && (mag_sat > MagLimit);
   assign cnt_inc  = {1'b0, cnt_ff} + (COUNT_WIDTH+1)'(1);
   assign at_limit = (cnt_inc == {1'b0, max_iter});

   // next z, floor shifts then saturate
   assign diff    = rr_ff - ii_ff;
   assign re_next = (diff >>> FRAC_BITS) + PW'(c_re_ff);
   assign im_next = (ri_ff >>> (FRAC_BITS - 1)) + PW'(c_im_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      load_job      = 1'b0;
      do_mul        = 1'b0;
      do_step       = 1'b0;
      finish        = 1'b0;
      out_count_in  = OutW'(cnt_ff);
      out_inside_in = 1'b1;
      out_mag_in    = mag_sat[MW-1:0];
      unique case (state_ff)
         meti_pkg::ENG_IDLE: begin
            if (!q_status.empty) begin
               load_job = 1'b1;
               state_in = meti_pkg::ENG_ADD;
            end
         end
         meti_pkg::ENG_ADD: begin
            priority if (first_ff && zero_ff) begin
               out_count_in = '0;
               out_mag_in   = '0;
               finish       = 1'b1;
            end else if (escape) begin
               out_inside_in = 1'b0;
               finish        = 1'b1;
            end else if (!first_ff && at_limit) begin
               out_count_in = OutW'(cnt_inc);
               finish       = 1'b1;
            end else begin
               do_step  = 1'b1;
               state_in = meti_pkg::ENG_MUL;
            end
            if (finish && out_free) begin
               state_in = meti_pkg::ENG_IDLE;
            end
         end
         meti_pkg::ENG_MUL: begin
            do_mul   = 1'b1;
            state_in = meti_pkg::ENG_ADD;
         end
         default: begin
            state_in = meti_pkg::ENG_IDLE;
         end
      endcase
   end

   assign pop = load_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= meti_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // iteration datapath
   always_ff @(posedge clock) begin
      if (load_job) begin
         c_re_ff  <= job.c_re;
         c_im_ff  <= job.c_im;
         zero_ff  <= job.zero_count;
         first_ff <= 1'b1;
         re_ff    <= '0;
         im_ff    <= '0;
         rr_ff    <= '0;
         ii_ff    <= '0;
         ri_ff    <= '0;
         cnt_ff   <= '0;
      end else if (do_step) begin
         re_ff    <= sat_z(re_next);
         im_ff    <= sat_z(im_next);
         first_ff <= 1'b0;
         if (!first_ff) begin
            cnt_ff <= cnt_inc[COUNT_WIDTH-1:0];
         end
      end else if (do_mul) begin
         rr_ff <= re_ff * re_ff;
         ii_ff <= im_ff * im_ff;
         ri_ff <= re_ff * im_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish && out_free) begin
         out_count_ff  <= out_count_in;
         out_inside_ff <= out_inside_in;
         out_re_ff     <= re_ff;
         out_im_ff     <= im_ff;
         out_mag_ff    <= out_mag_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.iteration_count = out_count_ff;
   assign rsp.inside_res      = out_inside_ff;
   assign rsp.z_re            = out_re_ff;
   assign rsp.z_im            = out_im_ff;
   assign rsp.magnitude_sq    = out_mag_ff;

endmodule

// ===== rtl/core/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core: Mandelbrot escape-time iterator
// Usage:
//   req_chan carries points c (c_re, c_im, signed fixed point, FRAC_BITS
//   fraction bits); rsp_chan returns one word per point: iteration_count,
//   inside_res, final z and |z|^2. Both use valid/ready; a word moves on a
//   clock edge with valid and ready high.
//   csr_wr_en/csr_wr_data write max_iterations (reset value 256); write it
//   only while no point is in flight.
//   A point passes an intake register and a two-entry job queue, then the
//   engine runs each iteration as a multiply step (three 32x32 products)
//   and an add/test step. Points are worked one at a time. A zero limit
//   gives a result with no iteration run.
//   The response register holds a finished word while the receiver stalls;
//   the engine then waits, and the queue and intake register keep taking up
//   to three points.
//   Synchronous reset empties the queue, idles the engine, drops any pending
//   response and restores max_iterations to 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   meti_req_if.sink                         req_chan,
   meti_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [meti_pkg::CSR_WIDTH-1:0]   csr_wr_data
);

   logic [COUNT_WIDTH-1:0]     max_iter_ff;
   logic                       push_valid;
   logic                       push_ready;
   meti_pkg::job_type          push_job;
   meti_pkg::job_type          pop_job;
   logic                       pop;
   meti_pkg::queue_status_type q_status;

   // iteration limit register, low COUNT_WIDTH bits kept
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= COUNT_WIDTH'(256);
      end else if (csr_wr_en) begin
         max_iter_ff <= COUNT_WIDTH'(csr_wr_data);
      end
   end

   meti_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .max_iter   (max_iter_ff),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   meti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_job    (pop_job),
      .status     (q_status)
   );

   meti_engine #(
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .max_iter (max_iter_ff),
      .q_status (q_status),
      .job      (pop_job),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   // engine only takes jobs that are there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("engine popped an empty queue");

   // an accepted request is in the intake slot next cycle
   a_accept_to_slot: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> push_valid)
      else $error("accepted request lost before the queue");

   // full queue with a waiting job backs up the request side
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      q_status.full && push_valid |-> !req_chan.ready)
      else $error("request taken while intake is blocked");

endmodule

// ===== dv/mandelbrot_escape_time_checker.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_checker: result predictor and scoreboard
// Watches the request, response and register ports of the escape-time core.
// Each accepted point is run through a fixed-point iteration of its own
// against a mirror of max_iterations. Each response word is compared field by
// field with the oldest prediction. Mismatches and the number of points still
// in flight are handed to the testbench top.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_checker #(
   parameter int FRAC_BITS   = 28,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   meti_req_if                              req_mon,
   meti_rsp_if                              rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [meti_pkg::CSR_WIDTH-1:0]   csr_wr_data,
   output int unsigned                      mismatch_count,
   output int                               points_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW   = meti_pkg::C_WIDTH;
   localparam int ZW   = meti_pkg::Z_WIDTH;
   localparam int MW   = meti_pkg::MAG_WIDTH;
   localparam int OutW = meti_pkg::CNT_OUT_WIDTH;

   // |z|^2 above 4.0 means the point has escaped
   localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << FRAC_BITS;

   typedef struct packed {
      logic [OutW-1:0]      iteration_count;
      logic                 inside_res;
      logic signed [ZW-1:0] z_re;
      logic signed [ZW-1:0] z_im;
      logic [MW-1:0]        magnitude_sq;
   } escape_result_type;

   logic [COUNT_WIDTH-1:0] iter_limit;
   escape_result_type      expected_escapes[$];

   // clamp a new z component to the signed 32-bit range
   function automatic longint clamp_z(input longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   // z <- z*z + c from z = 0, floor shifts after each exact product
   function automatic escape_result_type predict_escape(
      input logic signed [CW-1:0]   c_re,
      input logic signed [CW-1:0]   c_im,
      input logic [COUNT_WIDTH-1:0] limit
   );
      longint                 re;
      longint                 im;
      longint                 re_next;
      longint                 im_next;
      longint                 cr;
      longint                 ci;
      logic [63:0]            sq_sum;
      logic [COUNT_WIDTH-1:0] step;
      escape_result_type      res;
      cr             = longint'(c_re);
      ci             = longint'(c_im);
      re             = 0;
      im             = 0;
      sq_sum         = '0;
      step           = '0;
      res.inside_res = 1'b1;
      while (step < limit) begin
         re_next = ((re * re - im * im) >>> FRAC_BITS) + cr;
         im_next = ((re * im) >>> (FRAC_BITS - 1)) + ci;
         re      = clamp_z(re_next);
         im      = clamp_z(im_next);
         sq_sum  = ($unsigned(re * re) + $unsigned(im * im)) >> FRAC_BITS;
         if (sq_sum > meti_pkg::MAG_MAX)
            sq_sum = meti_pkg::MAG_MAX;
         if (sq_sum > ESCAPE_LIMIT) begin
            res.inside_res = 1'b0;
            break;
         end
         step++;
      end
      res.iteration_count = OutW'(step);
      res.z_re            = ZW'(re);
      res.z_im            = ZW'(im);
      res.magnitude_sq    = MW'(sq_sum);
      return res;
   endfunction

   // predict on request words, compare on response words
   always @(posedge clock) begin
      escape_result_type want;
      int unsigned       errs;
      errs = 0;
      if (reset) begin
         iter_limit       <= COUNT_WIDTH'(256);
         mismatch_count   <= 0;
         points_in_flight <= 0;
         expected_escapes.delete();
      end else begin
         if (csr_wr_en)
            iter_limit <= COUNT_WIDTH'(csr_wr_data);
         if (req_mon.valid && req_mon.ready)
            expected_escapes.push_back(predict_escape(req_mon.c_re, req_mon.c_im,
                                                      iter_limit));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_escapes.size() == 0) begin
               $error("response word with no point pending");
               errs++;
            end else begin
               want = expected_escapes.pop_front();
               if (rsp_mon.iteration_count !== want.iteration_count) begin
                  $error("iteration_count: expected %0d, got %0d",
                         want.iteration_count, rsp_mon.iteration_count);
                  errs++;
               end
               if (rsp_mon.inside_res !== want.inside_res) begin
                  $error("inside_res: expected %0d, got %0d",
                         want.inside_res, rsp_mon.inside_res);
                  errs++;
               end
               if (rsp_mon.z_re !== want.z_re) begin
                  $error("z_re: expected %0d, got %0d", want.z_re, rsp_mon.z_re);
                  errs++;
               end
               if (rsp_mon.z_im !== want.z_im) begin
                  $error("z_im: expected %0d, got %0d", want.z_im, rsp_mon.z_im);
                  errs++;
               end
               if (rsp_mon.magnitude_sq !== want.magnitude_sq) begin
                  $error("magnitude_sq: expected %0d, got %0d",
                         want.magnitude_sq, rsp_mon.magnitude_sq);
                  errs++;
               end
            end
         end
         mismatch_count   <= mismatch_count + errs;
         points_in_flight <= points_in_flight
                             + ((req_mon.valid && req_mon.ready) ? 1 : 0)
                             - ((rsp_mon.valid && rsp_mon.ready) ? 1 : 0);
      end
   end

endmodule

// ===== dv/mandelbrot_escape_time_core_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core_tb: testbench top of the escape-time core
// Drives points into the core under a series of max_iterations settings
// (reset value, zero, one, the largest count and several small ones), with
// random idle cycles on both channels, one long response stall and one long
// stretch without idling. The checker beside the core predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS       = 28;
   localparam int COUNT_WIDTH     = 16;
   localparam int IDLE_PCT        = 34;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CW              = meti_pkg::C_WIDTH;
   localparam int CSRW            = meti_pkg::CSR_WIDTH;

   // Q28 reference points; the c fields span [-4, 4)
   localparam int ONE   = 1 << FRAC_BITS;
   localparam int TWO   = 2 * ONE;
   localparam int C_MAX = (1 << (CW - 1)) - 1;
   localparam int C_MIN = -(1 << (CW - 1));

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSRW-1:0]      csr_wr_data;
   int unsigned          mismatch_count;
   int                   points_in_flight;
   logic                 calm;            // no idling on either side
   logic                 hold_off_ask;    // one long response stall
   logic                 hold_off_done;

   meti_req_if req_if ();
   meti_rsp_if rsp_if ();

   mandelbrot_escape_time_core #(
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mandelbrot_escape_time_checker #(
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(40_000_000);
      $display("FAIL mandelbrot_escape_time_core");
      $finish;
   end

   // response side: random stalls, one long hold-off
   initial begin
      hold_off_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_ask && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int special_c();
      unique case ($urandom_range(0, 7))
         0:       return 0;
         1:       return TWO;
         2:       return -TWO;
         3:       return C_MAX;
         4:       return C_MIN;
         5:       return ONE;
         6:       return -ONE;
         default: return 1;
      endcase
   endfunction

   // one request word, with random idle cycles ahead of it
   task automatic offer_point(input int re, input int im);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.c_re  <= CW'(re);
      req_if.c_im  <= CW'(im);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // mix of escaping, interior, slow boundary and out-of-range points
   task automatic random_points(input int count);
      int re;
      int im;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            re = span(-TWO, TWO);
            im = span(-TWO, TWO);
         end else if (pick < 65) begin
            re = span(-ONE / 4 * 3, ONE / 4);
            im = span(-ONE / 2, ONE / 2);
         end else if (pick < 75) begin
            if ($urandom_range(0, 1)) begin
               re = span(ONE / 4, ONE / 4 + ONE / 64);
               im = span(-ONE / 64, ONE / 64);
            end else begin
               re = span(-ONE / 4 * 3 - ONE / 64, -ONE / 4 * 3 + ONE / 64);
               im = span(-ONE / 32, ONE / 32);
            end
         end else if (pick < 90) begin
            re = int'($urandom());
            im = int'($urandom());
         end else begin
            re = special_c();
            im = special_c();
         end
         offer_point(re, im);
      end
   endtask

   // stop offering until every point has come back
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSRW-1:0] limit);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // stimulus and verdict
   initial begin
      reset        <= 1'b1;
      calm         <= 1'b0;
      hold_off_ask <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.c_re  <= '0;
      req_if.c_im  <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset limit of 256: fixed points, boundary of |z| = 2, early escapes
      offer_point(0, 0);
      offer_point(-TWO, 0);
      offer_point(TWO, 0);
      offer_point(0, TWO);
      offer_point(TWO, TWO);
      offer_point(-TWO, -TWO);
      offer_point(C_MAX, C_MAX);
      offer_point(C_MIN, C_MIN);
      offer_point(C_MIN, 0);
      offer_point(C_MAX, C_MIN);
      offer_point(-ONE, 0);
      offer_point(ONE / 4, 0);
      offer_point(0, ONE);
      offer_point(-ONE / 4 * 3, ONE / 10);
      offer_point(1, -1);

      // no iteration at all
      write_limit(16'd0);
      offer_point(TWO, TWO);
      random_points(60);

      write_limit(16'd1);
      random_points(80);

      // largest count: a few long interior runs
      write_limit(16'hFFFF);
      offer_point(0, 0);
      offer_point(-ONE, 0);
      random_points(1);

      // long stretch with no idling
      write_limit(16'd16);
      calm <= 1'b1;
      random_points(300);
      calm <= 1'b0;

      // receiver holds off while points keep coming
      write_limit(16'd3);
      hold_off_ask <= 1'b1;
      random_points(150);

      write_limit(16'd40);
      random_points(300);

      write_limit(16'd256);
      random_points(120);

      repeat (3) begin
         write_limit(CSRW'($urandom_range(2, 100)));
         random_points(100);
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS mandelbrot_escape_time_core");
      else
         $display("FAIL mandelbrot_escape_time_core");
      $finish;
   end

endmodule
